>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, sampled on clk, disabled while rst_n is low.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/smpd_pkg.sv
// Types, constants and helper functions for the serial mouse packet decoder.
package smpd_pkg;

    // Accumulator width; the output deltas are always 16 bits.
    localparam int SUM_WIDTH = 16;
    localparam int DELTA_WIDTH = 16;
    localparam int EXT_WIDTH = SUM_WIDTH + DELTA_WIDTH;

    // Serial byte and stream widths.
    localparam int BYTE_WIDTH = 7;
    localparam int IN_DATA_WIDTH = 8;
    localparam int BTN_WIDTH = 3;
    localparam int OUT_DATA_WIDTH = 40;
    localparam int OUT_PAD_WIDTH = OUT_DATA_WIDTH - 2 * DELTA_WIDTH - BTN_WIDTH;

    // Function codes carried on tuser.
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Byte position codes within a packet.
    localparam logic [2:0] POS_FIRST  = 3'd1;
    localparam logic [2:0] POS_SECOND = 3'd2;
    localparam logic [2:0] POS_THIRD  = 3'd3;
    localparam logic [2:0] POS_FOURTH = 3'd4;
    localparam logic [2:0] POS_WAIT   = 3'd5;

    // Bit positions inside a serial byte.
    localparam int START_BIT = 6;
    localparam int LEFT_BIT  = 5;
    localparam int RIGHT_BIT = 4;
    localparam int MID_BIT   = 5;

    // Output clamp limits at the extended width.
    localparam logic signed [EXT_WIDTH-1:0] OUT_MAX = EXT_WIDTH'(32767);
    localparam logic signed [EXT_WIDTH-1:0] OUT_MIN = EXT_WIDTH'(-32768);

    // One item handed to the decode core.
    typedef struct packed {
        logic                  valid;
        logic                  func;
        logic [BYTE_WIDTH-1:0] rx_byte;
    } step_t;

    // One read result.
    typedef struct packed {
        logic [BTN_WIDTH-1:0]          buttons;
        logic signed [DELTA_WIDTH-1:0] delta_y;
        logic signed [DELTA_WIDTH-1:0] delta_x;
    } result_t;

    // Saturating add of a sign-extended 8-bit delta to an accumulator.
    function automatic logic signed [SUM_WIDTH-1:0] sat_add(
        input logic signed [SUM_WIDTH-1:0] acc,
        input logic [7:0]                  d
    );
        logic signed [SUM_WIDTH:0] s;
        s = {acc[SUM_WIDTH-1], acc} + {{(SUM_WIDTH - 7){d[7]}}, d};
        if (s[SUM_WIDTH] != s[SUM_WIDTH-1])
            return s[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH - 1){1'b0}}}
                                : {1'b0, {(SUM_WIDTH - 1){1'b1}}};
        return s[SUM_WIDTH-1:0];
    endfunction

    // Clamp an accumulator to the 16-bit signed output range.
    function automatic logic signed [DELTA_WIDTH-1:0] clamp_out(
        input logic signed [SUM_WIDTH-1:0] acc
    );
        logic signed [EXT_WIDTH-1:0] e;
        e = {{DELTA_WIDTH{acc[SUM_WIDTH-1]}}, acc};
        if (e > OUT_MAX)
            return OUT_MAX[DELTA_WIDTH-1:0];
        if (e < OUT_MIN)
            return OUT_MIN[DELTA_WIDTH-1:0];
        return e[DELTA_WIDTH-1:0];
    endfunction

endpackage

>>> hdl/smpd_core.sv
// Packet assembly state, saturating accumulators and read result logic.
module smpd_core
    import smpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  step_t   step,
    output result_t result
);

    logic [2:0]                  pos_reg, pos_next;
    logic [7:0]                  px_reg, px_next;
    logic [7:0]                  py_reg, py_next;
    logic [BTN_WIDTH-1:0]        btn_reg, btn_next;
    logic signed [SUM_WIDTH-1:0] sum_x_reg, sum_x_next;
    logic signed [SUM_WIDTH-1:0] sum_y_reg, sum_y_next;
    logic [7:0]                  py_full;

    // The low Y bits arrive with the third byte, so the full Y is formed here.
    assign py_full = py_reg | {1'b0, step.rx_byte};

    // Next-state logic for one beat.
    always_comb
    begin
        pos_next   = pos_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        btn_next   = btn_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        if (step.valid)
        begin
            if (step.func == FUNC_READ)
            begin
                sum_x_next = '0;
                sum_y_next = '0;
            end
            else if (step.rx_byte[START_BIT])
            begin
                btn_next = {1'b0, step.rx_byte[RIGHT_BIT], step.rx_byte[LEFT_BIT]};
                px_next  = {step.rx_byte[1:0], 6'b0};
                py_next  = {step.rx_byte[3:2], 6'b0};
                pos_next = POS_FIRST;
            end
            else
            begin
                unique case (pos_reg)
                    POS_FIRST:
                    begin
                        px_next = px_reg | {1'b0, step.rx_byte};
                    end
                    POS_SECOND:
                    begin
                        py_next    = py_full;
                        sum_x_next = sat_add(sum_x_reg, px_reg);
                        sum_y_next = sat_add(sum_y_reg, py_full);
                    end
                    POS_THIRD:
                    begin
                        if (step.rx_byte[MID_BIT])
                            btn_next = btn_reg | 3'b100;
                    end
                    default:
                    begin
                    end
                endcase
                if (pos_reg < POS_WAIT)
                    pos_next = pos_reg + 3'd1;
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_WAIT;
            px_reg    <= '0;
            py_reg    <= '0;
            btn_reg   <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            btn_reg   <= btn_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
        end
    end

    // Read result from the state before this beat.
    assign result.delta_x = clamp_out(sum_x_reg);
    assign result.delta_y = clamp_out(sum_y_reg);
    assign result.buttons = btn_reg;

endmodule

>>> hdl/serial_mouse_packet_decoder_top.sv
// Top level of the serial mouse packet decoder: input register, core, result register.
//
// Each slave beat carries one serial byte (tuser low) or a read request (tuser high).
// A beat passes through an input register and is decoded as it leaves it, so one
// beat per clock is taken as long as the master side keeps up. Serial bytes give
// no result; a read gives one master beat through the result register, with the
// motion summed since the previous read and the current buttons, then clears
// the sums. A read waits in the input register only while an earlier result is
// still held on the master side.
module serial_mouse_packet_decoder_top
    import smpd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_DATA_WIDTH-1:0]  s_tdata,   // [6:0] rx_byte, [7] zero
    input  logic                      s_tuser,   // [0] func
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_WIDTH-1:0] m_tdata    // [15:0] delta_x, [31:16] delta_y,
                                                 // [34:32] buttons, [39:35] zero
);

    logic                  in_valid_reg, in_valid_next;
    logic                  in_func_reg;
    logic [BYTE_WIDTH-1:0] in_byte_reg;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg;
    result_t               core_result;
    step_t                 step;
    logic                  advance;
    logic                  s_fire;

    // A held beat moves on unless it is a read and the result register is blocked.
    assign advance  = in_valid_reg &&
                      (in_func_reg == FUNC_BYTE || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    assign step.valid   = advance;
    assign step.func    = in_func_reg;
    assign step.rx_byte = in_byte_reg;

    smpd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .result (core_result)
    );

    // Input register valid flag.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    // Result register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && in_func_reg == FUNC_READ)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_func_reg <= s_tuser;
            in_byte_reg <= s_tdata[BYTE_WIDTH-1:0];
        end
        if (advance && in_func_reg == FUNC_READ)
            out_reg <= core_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_WIDTH{1'b0}}, out_reg};

endmodule

>>> hdl/smpd_checker.sv
// Port-level checker for the serial mouse packet decoder, bound to the top level.
`include "assert_macros.svh"

module smpd_checker
    import smpd_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      s_tuser,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [OUT_DATA_WIDTH-1:0] m_tdata
);

    logic                     read_beat;
    logic [OUT_PAD_WIDTH-1:0] out_pad;

    assign read_beat = s_tvalid && s_tready && s_tuser == FUNC_READ;
    assign out_pad   = m_tdata[OUT_DATA_WIDTH-1:2*DELTA_WIDTH+BTN_WIDTH];

    // A stalled result beat stays offered.
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")

    // A stalled result beat keeps its payload.
    `ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

    // A new result comes from a read beat taken through the input and result registers.
    `ASSERT_IMP(a_out_from_read, $rose(m_tvalid), $past(read_beat, 2), "result without a read")

    // With the result register empty, the block always takes a beat.
    `ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready, "input stalled while output empty")

    // The padding above the buttons is always zero.
    `ASSERT_IMP(a_pad_zero, m_tvalid, out_pad == '0, "nonzero padding in result")

endmodule

bind serial_mouse_packet_decoder_top smpd_checker u_smpd_checker (.*);

>>> tb/serial_mouse_packet_decoder_top_test.sv
// Self-checking stream testbench for the serial mouse packet decoder top level.
`timescale 1ns / 100ps

module serial_mouse_packet_decoder_top_test;
    import smpd_pkg::*;

    // Tracks packet assembly, button state and the saturating motion sums, and
    // keeps the read reports that the block still owes.
    class motion_tracker;
        logic [2:0]           byte_pos;
        logic [7:0]           part_x;
        logic [7:0]           part_y;
        logic [BTN_WIDTH-1:0] btn_state;
        longint               sum_x;
        longint               sum_y;
        result_t              owed_reports[$];
        int                   mismatches;

        function new();
            byte_pos = POS_WAIT;
            part_x = '0;
            part_y = '0;
            btn_state = '0;
            sum_x = 0;
            sum_y = 0;
            mismatches = 0;
        endfunction

        // Limits a value to the signed range of the given width.
        function longint clamp_to(longint v, int width);
            longint hi;
            longint lo;
            hi = (longint'(1) << (width - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        function int pending();
            return owed_reports.size();
        endfunction

        // Updates the state for one accepted input beat.
        function void note_beat(logic func, logic [BYTE_WIDTH-1:0] rx);
            result_t report;
            longint  step_x;
            longint  step_y;
            if (func == FUNC_READ)
            begin
                report.delta_x = DELTA_WIDTH'(clamp_to(sum_x, DELTA_WIDTH));
                report.delta_y = DELTA_WIDTH'(clamp_to(sum_y, DELTA_WIDTH));
                report.buttons = btn_state;
                owed_reports.push_back(report);
                sum_x = 0;
                sum_y = 0;
                return;
            end
            // A start byte restarts the packet whatever came before.
            if (rx[START_BIT])
            begin
                btn_state = {1'b0, rx[RIGHT_BIT], rx[LEFT_BIT]};
                part_x = {rx[1:0], 6'd0};
                part_y = {rx[3:2], 6'd0};
                byte_pos = POS_FIRST;
                return;
            end
            case (byte_pos)
                POS_FIRST:
                    part_x = part_x | {1'b0, rx};
                POS_SECOND:
                begin
                    part_y = part_y | {1'b0, rx};
                    step_x = $signed(part_x);
                    step_y = $signed(part_y);
                    sum_x = clamp_to(sum_x + step_x, SUM_WIDTH);
                    sum_y = clamp_to(sum_y + step_y, SUM_WIDTH);
                end
                POS_THIRD:
                    if (rx[MID_BIT])
                        btn_state[2] = 1'b1;
                default:
                    ;
            endcase
            if (byte_pos < POS_WAIT)
                byte_pos = byte_pos + 3'd1;
        endfunction

        // Compares one result beat with the oldest owed report.
        function void check_report(logic [OUT_DATA_WIDTH-1:0] data);
            result_t                      want;
            logic signed [DELTA_WIDTH-1:0] got_x;
            logic signed [DELTA_WIDTH-1:0] got_y;
            logic [BTN_WIDTH-1:0]          got_btn;
            logic [OUT_PAD_WIDTH-1:0]      got_pad;
            if (owed_reports.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat %h with no read outstanding", $time, data);
                return;
            end
            want = owed_reports.pop_front();
            got_x = data[DELTA_WIDTH-1:0];
            got_y = data[2*DELTA_WIDTH-1:DELTA_WIDTH];
            got_btn = data[2*DELTA_WIDTH+BTN_WIDTH-1:2*DELTA_WIDTH];
            got_pad = data[OUT_DATA_WIDTH-1:2*DELTA_WIDTH+BTN_WIDTH];
            if (got_x !== want.delta_x)
            begin
                mismatches++;
                $display("%0t: delta_x expected %0d, got %0d", $time, want.delta_x, got_x);
            end
            if (got_y !== want.delta_y)
            begin
                mismatches++;
                $display("%0t: delta_y expected %0d, got %0d", $time, want.delta_y, got_y);
            end
            if (got_btn !== want.buttons)
            begin
                mismatches++;
                $display("%0t: buttons expected %b, got %b", $time, want.buttons, got_btn);
            end
            if (got_pad !== '0)
            begin
                mismatches++;
                $display("%0t: padding expected 0, got %b", $time, got_pad);
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_DATA_WIDTH-1:0]  s_tdata = '0;   // [6:0] rx_byte, [7] zero
    logic                      s_tuser = FUNC_BYTE;   // [0] func
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_DATA_WIDTH-1:0] m_tdata;   // [15:0] delta_x, [31:16] delta_y,
                                          // [34:32] buttons, [39:35] zero

    motion_tracker tracker = new();
    int            src_idle_pct = 0;
    int            dst_stall_pct = 0;
    int            beats_sent = 0;

    // Directed beats: func in bit 7, serial byte below.
    logic [7:0] directed_beats[] = '{
        // Bytes before any start byte are dropped; the first read sees nothing.
        {FUNC_BYTE, 7'h00}, {FUNC_BYTE, 7'h3F}, {FUNC_READ, 7'h7F},
        // Full four-byte packet: X = -128, Y = +127, all buttons, then a stray byte.
        {FUNC_BYTE, 7'h76}, {FUNC_BYTE, 7'h00}, {FUNC_BYTE, 7'h3F},
        {FUNC_BYTE, 7'h20}, {FUNC_BYTE, 7'h3F}, {FUNC_READ, 7'h00},
        // Packet cut short by a new start byte, then a full packet (63, -64)
        // and one with every bit set (-1, -1) and a fourth byte without middle.
        {FUNC_BYTE, 7'h43}, {FUNC_BYTE, 7'h3F}, {FUNC_BYTE, 7'h4C},
        {FUNC_BYTE, 7'h3F}, {FUNC_BYTE, 7'h00}, {FUNC_BYTE, 7'h7F},
        {FUNC_BYTE, 7'h3F}, {FUNC_BYTE, 7'h3F}, {FUNC_BYTE, 7'h1F},
        {FUNC_READ, 7'h00},
        // A read in the middle of a packet keeps the packet going.
        {FUNC_BYTE, 7'h40}, {FUNC_READ, 7'h55}, {FUNC_BYTE, 7'h01},
        {FUNC_BYTE, 7'h02}, {FUNC_READ, 7'h2A}
    };

    serial_mouse_packet_decoder_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge clk)
    begin
        m_tready = ($urandom_range(0, 99) >= dst_stall_pct);
    end

    // Result beats are taken and checked on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_report(m_tdata);
    end

    // Drives one beat, with random idle cycles ahead of it, and notes it once taken.
    task automatic send_beat(logic func, logic [BYTE_WIDTH-1:0] rx);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = func;
        s_tdata = {1'b0, rx};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_beat(func, rx);
        beats_sent++;
        @(negedge clk);
    endtask

    // Holds the sender off until every owed report has arrived.
    task automatic wait_for_drain();
        if (tracker.pending() != 0)
        begin
            s_tvalid = 1'b0;
            while (tracker.pending() != 0)
                @(negedge clk);
        end
    endtask

    // Serial byte, now and then preceded by a read that can land mid-packet.
    task automatic send_serial(logic [BYTE_WIDTH-1:0] rx);
        if ($urandom_range(0, 99) < 6)
            send_beat(FUNC_READ, BYTE_WIDTH'($urandom));
        send_beat(FUNC_BYTE, rx);
    endtask

    function automatic logic [BYTE_WIDTH-1:0] start_byte();
        return {1'b1, 6'($urandom)};
    endfunction

    function automatic logic [BYTE_WIDTH-1:0] body_byte();
        return {1'b0, 6'($urandom)};
    endfunction

    // Mostly well-formed packets with random content, plus reads, noise and
    // packets broken off early.
    task automatic run_random(int n_beats);
        int target;
        int kind;
        int extra;
        target = beats_sent + n_beats;
        while (beats_sent < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 2)
                wait_for_drain();
            else if (kind < 14)
                send_beat(FUNC_READ, BYTE_WIDTH'($urandom));
            else if (kind < 22)
                send_beat(FUNC_BYTE, BYTE_WIDTH'($urandom));
            else if (kind < 30)
            begin
                send_serial(start_byte());
                extra = $urandom_range(0, 1);
                repeat (extra)
                    send_serial(body_byte());
            end
            else
            begin
                send_serial(start_byte());
                send_serial(body_byte());
                send_serial(body_byte());
                if ($urandom_range(0, 99) < 40)
                    send_serial(body_byte());
                if ($urandom_range(0, 99) < 10)
                    send_serial(body_byte());
            end
        end
    endtask

    // Long run of extreme packets with the same motion and random buttons, with no
    // read, driving both sums into saturation, then a read.
    task automatic run_pileup(logic [7:0] step_x, logic [7:0] step_y, int packets);
        repeat (packets)
        begin
            send_beat(FUNC_BYTE, {1'b1, 2'($urandom), step_y[7:6], step_x[7:6]});
            send_beat(FUNC_BYTE, {1'b0, step_x[5:0]});
            send_beat(FUNC_BYTE, {1'b0, step_y[5:0]});
        end
        send_beat(FUNC_READ, BYTE_WIDTH'($urandom));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_beats[i])
            send_beat(directed_beats[i][7], directed_beats[i][6:0]);
        wait_for_drain();

        // No idling on either side.
        run_random(150);
        run_pileup(8'h7F, 8'h80, 262);
        wait_for_drain();

        // Sender idle most of the time.
        src_idle_pct = 65;
        dst_stall_pct = 0;
        run_random(150);
        wait_for_drain();

        // Receiver stalling most of the time.
        src_idle_pct = 0;
        dst_stall_pct = 65;
        run_random(150);
        run_pileup(8'h80, 8'h7F, 262);
        wait_for_drain();

        // Both sides idling.
        src_idle_pct = 34;
        dst_stall_pct = 34;
        run_random(150);

        s_tvalid = 1'b0;
        wait_for_drain();
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("serial_mouse_packet_decoder_top verification clean");
        else
            $display("serial_mouse_packet_decoder_top verification failed");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("serial_mouse_packet_decoder_top verification failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/smpd_pkg.sv
hdl/smpd_core.sv
hdl/serial_mouse_packet_decoder_top.sv
hdl/smpd_checker.sv
tb/serial_mouse_packet_decoder_top_test.sv
